@@ hdl/chmt_pkg.sv @@
package chmt_pkg;

	localparam int CordicMax = 24;
	localparam int AngW = 32;
	localparam int TenthsPerTurn = 3600;

	typedef enum logic [1:0] {
		CFG_X_OFFSET = 2'd0,
		CFG_Y_OFFSET = 2'd1,
		CFG_Z_OFFSET = 2'd2,
		CFG_DECL     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_SCALE,
		ST_WRAP,
		ST_OUT
	} state_t;

	function automatic logic [AngW-1:0] atan_turn(input logic [4:0] i);
		logic [AngW-1:0] r;
		begin
			case (i)
				5'd0: r = 32'h20000000;
				5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B;
				5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43;
				5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E;
				5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53;
				5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2F9;
				5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30;
				5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C;
				5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3;
				5'd23: r = 32'h00000051;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ hdl/compass_heading_magnitude_tracker_unit.sv @@
// an input beat passes the prep, cordic run, scale and wrap states before the
// result beat is offered
// no new beat is taken until the result leaves
// the square root chain (SAMPLE_BITS+1 cells) finishes before the wrap state takes its root
// reset: minima to the most positive sample, maxima to the most negative,
// offsets and declination to zero, no result pending
module compass_heading_magnitude_tracker_unit #(
	parameter int SAMPLE_BITS = 12,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [3*SAMPLE_BITS+((8-(3*SAMPLE_BITS)%8)%8)-1:0] s_tdata, // mag_x, mag_y, mag_z
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [14+8*SAMPLE_BITS+((8-(14+8*SAMPLE_BITS)%8)%8)-1:0] m_tdata,
	// heading, magnitude_xy, magnitude_xyz, min_x/y/z_seen, max_x/y/z_seen
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12)-1:0] cfg_data
);
	import chmt_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int RW = SB + 1;
	localparam int NW = 2 * SB + 4;
	localparam int CW = SB + 2 + 24 + 2;
	localparam int IT = (ANGLE_ITERATIONS < CordicMax) ? ANGLE_ITERATIONS : CordicMax;
	// run long enough for the square root chain to settle as well
	localparam int RL = (IT > SB) ? IT : SB;
	localparam int MW = $bits(m_tdata);

	logic signed [SB-1:0] xo_q, yo_q, zo_q;
	logic signed [11:0]   decl_q;
	logic signed [SB-1:0] lx_q, ly_q, lz_q, hx_q, hy_q, hz_q;
	logic signed [DW-1:0] dx_q, dy_q, dz_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [AngW-1:0]      ang_q;
	logic [4:0]           it_q;
	logic [AngW+12-1:0]   prod_q;
	logic [11:0]          hd_q;
	logic [NW-1:0]        sxy_q, sxyz_q;
	logic [RW-1:0]        rxy, rxyz;
	logic [MW-1:0]        out_q;
	logic                 zero_q;
	state_t state_q, state_d;

	logic signed [SB-1:0] rx, ry, rz;
	assign rx = s_tdata[SB-1:0];
	assign ry = s_tdata[2*SB-1:SB];
	assign rz = s_tdata[3*SB-1:2*SB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xo_q <= '0; yo_q <= '0; zo_q <= '0; decl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_OFFSET: xo_q <= cfg_data[SB-1:0];
				CFG_Y_OFFSET: yo_q <= cfg_data[SB-1:0];
				CFG_Z_OFFSET: zo_q <= cfg_data[SB-1:0];
				CFG_DECL:     decl_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_RUN;
			ST_RUN: if (it_q == 5'(RL - 1)) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_WRAP;
			ST_WRAP: state_d = ST_OUT;
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// running extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= {1'b0, {(SB-1){1'b1}}}; ly_q <= {1'b0, {(SB-1){1'b1}}};
			lz_q <= {1'b0, {(SB-1){1'b1}}};
			hx_q <= {1'b1, {(SB-1){1'b0}}}; hy_q <= {1'b1, {(SB-1){1'b0}}};
			hz_q <= {1'b1, {(SB-1){1'b0}}};
		end else if (s_tvalid && s_tready) begin
			if (rx < lx_q) lx_q <= rx;
			if (ry < ly_q) ly_q <= ry;
			if (rz < lz_q) lz_q <= rz;
			if (rx > hx_q) hx_q <= rx;
			if (ry > hy_q) hy_q <= ry;
			if (rz > hz_q) hz_q <= rz;
		end
	end

	logic signed [2*DW-1:0] px, py, pz;
	assign px = dx_q * dx_q;
	assign py = dy_q * dy_q;
	assign pz = dz_q * dz_q;

	logic signed [CW-1:0] shx, shy;
	assign shx = cx_q >>> it_q;
	assign shy = cy_q >>> it_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				dx_q <= DW'(rx) - DW'(xo_q);
				dy_q <= DW'(ry) - DW'(yo_q);
				dz_q <= DW'(rz) - DW'(zo_q);
			end
			ST_PREP: begin
				sxy_q  <= NW'(unsigned'(px)) + NW'(unsigned'(py));
				sxyz_q <= NW'(unsigned'(px)) + NW'(unsigned'(py)) + NW'(unsigned'(pz));
				zero_q <= (dx_q == '0) && (dy_q == '0);
				it_q <= '0;
				if (dx_q < 0) begin
					cx_q <= -(CW'(dx_q) <<< 24);
					cy_q <= -(CW'(dy_q) <<< 24);
					ang_q <= 32'h80000000;
				end else begin
					cx_q <= CW'(dx_q) <<< 24;
					cy_q <= CW'(dy_q) <<< 24;
					ang_q <= '0;
				end
			end
			ST_RUN: begin
				it_q <= it_q + 5'd1;
				if (it_q < 5'(IT)) begin
					if (cy_q > 0) begin
						cx_q <= cx_q + shy;
						cy_q <= cy_q - shx;
						ang_q <= ang_q + atan_turn(it_q);
					end else begin
						cx_q <= cx_q - shy;
						cy_q <= cy_q + shx;
						ang_q <= ang_q - atan_turn(it_q);
					end
				end
			end
			ST_SCALE: prod_q <= (zero_q ? 44'd0 : 44'(ang_q) * 44'd3600) + 44'h80000000;
			ST_WRAP: begin
				logic [12:0] t;
				logic signed [14:0] h;
				t = 13'(prod_q[43:32]);
				if (t >= 13'd3600) t = t - 13'd3600;
				h = 15'(t) + 15'(decl_q);
				if (h < 0) h = h + 15'sd3600;
				if (h < 0) h = h + 15'sd3600;
				if (h >= 15'sd3600) h = h - 15'sd3600;
				if (h >= 15'sd3600) h = h - 15'sd3600;
				hd_q <= h[11:0];
				out_q <= MW'({hz_q, hy_q, hx_q, lz_q, ly_q, lx_q, rxyz, rxy, h[11:0]});
			end
			default: ;
		endcase
	end

	chmt_sqrt_chain #(.NW(NW), .RW(RW)) u_sq_xy (
		.clk(clk), .en(1'b1), .value(sxy_q), .root(rxy));
	chmt_sqrt_chain #(.NW(NW), .RW(RW)) u_sq_xyz (
		.clk(clk), .en(1'b1), .value(sxyz_q), .root(rxyz));

	assign m_tdata = out_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output both open");
	a_head_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> hd_q < 12'd3600) else $error("heading out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(out_q)) else $error("result lost");
	a_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> lx_q <= hx_q) else $error("extremes crossed");
endmodule

@@ hdl/chmt_sqrt_cell.sv @@
// one cell of a digit-by-digit square root chain; each cell settles one root bit
module chmt_sqrt_cell #(
	parameter int NW = 40,
	parameter int RW = 13,
	parameter int BITPOS = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] rem_in,
	input  logic [RW-1:0] root_in,
	output logic [NW-1:0] rem_q,
	output logic [RW-1:0] root_q
);
	logic [NW-1:0] trial;
	logic [NW-1:0] root_ext;

	assign root_ext = NW'(root_in);
	// (2r + b) * b with b = 2^BITPOS, r holding only higher bits
	assign trial = (root_ext << (BITPOS + 1)) + (NW'(1) << (2 * BITPOS));

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= root_in | (RW'(1) << BITPOS);
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in;
			end
		end
	end
endmodule

@@ hdl/chmt_sqrt_chain.sv @@
module chmt_sqrt_chain #(
	parameter int NW = 40,
	parameter int RW = 13
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] value,
	output logic [RW-1:0] root
);
	logic [NW-1:0] rem_w  [RW+1];
	logic [RW-1:0] root_w [RW+1];

	assign rem_w[0]  = value;
	assign root_w[0] = '0;

	for (genvar g = 0; g < RW; g++) begin : g_cell
		chmt_sqrt_cell #(.NW(NW), .RW(RW), .BITPOS(RW - 1 - g)) u_cell (
			.clk(clk), .en(en),
			.rem_in(rem_w[g]), .root_in(root_w[g]),
			.rem_q(rem_w[g+1]), .root_q(root_w[g+1])
		);
	end

	assign root = root_w[RW];
endmodule

@@ sim/compass_heading_magnitude_tracker_unit_test.sv @@
`timescale 1ns / 1ps

module compass_heading_magnitude_tracker_unit_test;
	import chmt_pkg::*;

	localparam int Rotations = 16;
	localparam int DrainCycles = 30;
	localparam int StallLimit = 5000;

	localparam logic [31:0] TurnStep [0:15] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D
	};

	typedef struct packed {
		logic [11:0] heading;
		logic [12:0] mag_xy;
		logic [12:0] mag_xyz;
		logic signed [11:0] min_x;
		logic signed [11:0] min_y;
		logic signed [11:0] min_z;
		logic signed [11:0] max_x;
		logic signed [11:0] max_y;
		logic signed [11:0] max_z;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0; // mag_x, mag_y, mag_z, zero pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [111:0] m_tdata; // heading, magnitude_xy, magnitude_xyz, min x/y/z, max x/y/z, pad
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	fix_t pending_fixes [$];
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;
	int err_count = 0;

	// predictor state
	logic signed [11:0] off_x = 0, off_y = 0, off_z = 0, decl = 0;
	logic signed [11:0] lo_x = 12'sd2047, lo_y = 12'sd2047, lo_z = 12'sd2047;
	logic signed [11:0] hi_x = -12'sd2048, hi_y = -12'sd2048, hi_z = -12'sd2048;

	compass_heading_magnitude_tracker_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] vector_angle(input longint x, input longint y);
		logic [31:0] z;
		longint nx;
		z = '0;
		if (x == 0 && y == 0) return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		x = x * (64'sd1 <<< 24);
		y = y * (64'sd1 <<< 24);
		for (int i = 0; i < Rotations; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + TurnStep[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - TurnStep[i];
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic fix_t track_fix(input logic signed [11:0] rx, input logic signed [11:0] ry,
			input logic signed [11:0] rz);
		fix_t f;
		longint dx, dy, dz, h;
		logic [63:0] t;
		dx = longint'(rx) - longint'(off_x);
		dy = longint'(ry) - longint'(off_y);
		dz = longint'(rz) - longint'(off_z);
		t = ({32'd0, vector_angle(dx, dy)} * 64'd3600 + 64'h80000000) >> 32;
		if (t >= 3600) t = t - 3600;
		h = longint'(t) + longint'(decl);
		h = ((h % 3600) + 3600) % 3600;
		if (rx < lo_x) lo_x = rx;
		if (ry < lo_y) lo_y = ry;
		if (rz < lo_z) lo_z = rz;
		if (rx > hi_x) hi_x = rx;
		if (ry > hi_y) hi_y = ry;
		if (rz > hi_z) hi_z = rz;
		f.heading = h[11:0];
		f.mag_xy = 13'(floor_sqrt(dx * dx + dy * dy));
		f.mag_xyz = 13'(floor_sqrt(dx * dx + dy * dy + dz * dz));
		f.min_x = lo_x;
		f.min_y = lo_y;
		f.min_z = lo_z;
		f.max_x = hi_x;
		f.max_y = hi_y;
		f.max_z = hi_z;
		return f;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		fix_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fixes.size() == 0) begin
				$error("result beat with nothing pending, data %h", m_tdata);
				err_count++;
			end else begin
				want = pending_fixes.pop_front();
				check_field("heading", want.heading, m_tdata[11:0]);
				check_field("magnitude_xy", want.mag_xy, m_tdata[24:12]);
				check_field("magnitude_xyz", want.mag_xyz, m_tdata[37:25]);
				check_field("min_x_seen", want.min_x, $signed(m_tdata[49:38]));
				check_field("min_y_seen", want.min_y, $signed(m_tdata[61:50]));
				check_field("min_z_seen", want.min_z, $signed(m_tdata[73:62]));
				check_field("max_x_seen", want.max_x, $signed(m_tdata[85:74]));
				check_field("max_y_seen", want.max_y, $signed(m_tdata[97:86]));
				check_field("max_z_seen", want.max_z, $signed(m_tdata[109:98]));
			end
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < StallLimit) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(input logic signed [11:0] x, input logic signed [11:0] y,
			input logic signed [11:0] z);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, z, y, x};
		pending_fixes.push_back(track_fix(x, y, z));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_fixes.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_X_OFFSET: off_x = val;
			CFG_Y_OFFSET: off_y = val;
			CFG_Z_OFFSET: off_z = val;
			CFG_DECL: decl = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [11:0] ox, input logic [11:0] oy,
			input logic [11:0] oz, input logic [11:0] dc);
		write_reg(CFG_X_OFFSET, ox);
		write_reg(CFG_Y_OFFSET, oy);
		write_reg(CFG_Z_OFFSET, oz);
		write_reg(CFG_DECL, dc);
	endtask

	task automatic test_extremes;
		send_sample(-12'sd2048, -12'sd2048, -12'sd2048);
		send_sample(12'sd2047, 12'sd2047, 12'sd2047);
		send_sample(12'sd2047, -12'sd2048, 12'sd0);
		send_sample(-12'sd2048, 12'sd2047, 12'sd5);
		set_all(12'h800, 12'h7FF, 12'h800, 12'd1800);
		send_sample(12'sd2047, -12'sd2048, 12'sd2047);
		send_sample(-12'sd2048, 12'sd2047, -12'sd2048);
		send_sample(12'sd0, 12'sd0, 12'sd0);
	endtask

	task automatic test_axes_and_zero;
		// zero vector gives the bare declination, dy zero lands on an axis
		set_all(12'd100, -12'sd50, 12'd7, -12'sd1800);
		send_sample(12'sd100, -12'sd50, 12'sd7);
		send_sample(12'sd300, -12'sd50, 12'sd0);
		send_sample(-12'sd300, -12'sd50, 12'sd0);
		send_sample(12'sd100, 12'sd900, 12'sd0);
		send_sample(12'sd100, -12'sd900, 12'sd0);
		write_reg(CFG_DECL, 12'h7FF);
		send_sample(12'sd100, -12'sd50, 12'sd7);
		send_sample(12'sd101, -12'sd49, 12'sd7);
		write_reg(CFG_DECL, 12'h800);
		send_sample(12'sd100, -12'sd50, 12'sd7);
		send_sample(-12'sd1, -12'sd51, 12'sd8);
		write_reg(CFG_DECL, 12'd0);
		send_sample(12'sd101, -12'sd50, -12'sd7);
	endtask

	task automatic test_random_phase(input int src_pct, input int sink_pct, input int count);
		logic signed [11:0] x, y, z;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 140 == 0) begin
				case ($urandom_range(0, 3))
					0: set_all(12'h800, 12'h800, 12'h7FF, 12'd1800);
					1: set_all(12'h7FF, 12'h7FF, 12'h800, -12'sd1800);
					default: set_all(12'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom_range(0, 3600)) - 12'd1800);
				endcase
			end
			if (n == count / 2) drain();
			if ($urandom_range(0, 9) < 2) begin
				// small vectors around the offsets hit zero and the axes
				x = off_x + 12'($urandom_range(0, 6)) - 12'sd3;
				y = off_y + 12'($urandom_range(0, 6)) - 12'sd3;
				z = off_z + 12'($urandom_range(0, 6)) - 12'sd3;
			end else begin
				x = 12'($urandom);
				y = 12'($urandom);
				z = 12'($urandom);
			end
			send_sample(x, y, z);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_pct = 35;
		sink_stall_pct = 64;
		test_extremes();
		test_axes_and_zero();
		test_random_phase(35, 64, 560);
		test_random_phase(64, 35, 560);
		test_random_phase(0, 0, 560);
		drain();
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
